>>> sv/usf_pkg.sv
// Package for the UTF-8 stream sanitiser: byte constants, the shared
// classification result and the control structs between the sequencer and
// the output stage. No dependencies.
package usf_pkg;

   localparam logic [7:0] CHR_TAB        = 8'd9;
   localparam logic [7:0] CHR_LF         = 8'd10;
   localparam logic [7:0] CHR_CR         = 8'd13;
   localparam logic [7:0] CHR_SPACE      = 8'd32;
   localparam logic [7:0] CHR_DEL        = 8'd127;
   localparam logic [7:0] CHR_EURO_IN    = 8'd128;
   localparam logic [7:0] CHR_NEL        = 8'd133;
   localparam logic [7:0] CHR_NBSP       = 8'd160;
   localparam logic [7:0] CHR_LEAD_MIN   = 8'd192;
   localparam logic [7:0] CHR_LEAD2      = 8'd194;
   localparam logic [7:0] CHR_LEAD3      = 8'd224;
   localparam logic [7:0] CHR_LEAD4      = 8'd240;
   localparam logic [7:0] CHR_LEAD_END   = 8'd245;
   localparam logic [7:0] CHR_CONT_MIN   = 8'd128;
   localparam logic [7:0] CHR_CONT_MAX   = 8'd191;
   localparam logic [7:0] EURO_B0        = 8'd226;
   localparam logic [7:0] EURO_B1        = 8'd130;
   localparam logic [7:0] EURO_B2        = 8'd172;
   localparam logic [7:0] PFX_C2         = 8'd194;
   localparam logic [7:0] PFX_C3         = 8'd195;
   localparam logic [7:0] LATIN1_OFFSET  = 8'd64;

   // window of pending bytes plus the new one, entry 0 is the oldest
   typedef logic [3:0][7:0] usf_window_type;

   typedef struct packed {
      logic           stall;   // incomplete lead, hold for more bytes
      logic [2:0]     count;   // bytes to emit, 0..4
      logic [2:0]     adv;     // bytes consumed from the window, 1..4
      usf_window_type data;    // bytes to emit, entry 0 first
   } usf_cls_type;

   typedef struct packed {
      logic       push;
      logic       flush;
      logic [7:0] data;
   } usf_emit_cmd_type;

   typedef struct packed {
      logic push_ok;
      logic flush_ok;
      logic held;
   } usf_emit_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_FINISH
   } usf_state_type;

endpackage

>>> sv/utf8_stream_sanitizer.sv
// UTF-8 stream sanitiser, top level: window registers, sequencer, shared
// classification unit and output stage. Uses usf_pkg, usf_classify, usf_emit.
//
// Each request carries one raw byte and an end-of-string flag; the block
// answers with zero or more cleaned UTF-8 bytes, the final one of a request
// flagged by rsp_out_last. A request that produces nothing gives no
// response. Up to three bytes of an unfinished multi-byte sequence are held
// between requests; the end flag flushes them. The sequencer runs one
// classification per character and pushes one byte per cycle into the
// output stage while it can take them; a byte waits while rsp_ready is
// low and both the holding and the response register are full.
// req_ready is high only between requests.
module utf8_stream_sanitizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   usf_pkg::usf_state_type    state_ff, state_in;
   usf_pkg::usf_window_type   win_ff, win_in;
   logic [2:0]                cnt_ff, cnt_in;
   logic                      end_ff, end_in;
   logic [2:0]                idx_ff, idx_in;
   usf_pkg::usf_cls_type      cls_ff, cls_in;
   usf_pkg::usf_cls_type      cls;
   usf_pkg::usf_emit_cmd_type cmd;
   usf_pkg::usf_emit_sts_type sts;
   logic [2:0]                src;

   usf_classify u_classify (
      .win         (win_ff),
      .cnt         (cnt_ff),
      .last_in_str (end_ff),
      .cls         (cls)
   );

   usf_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always_comb begin
      state_in  = state_ff;
      win_in    = win_ff;
      cnt_in    = cnt_ff;
      end_in    = end_ff;
      idx_in    = idx_ff;
      cls_in    = cls_ff;
      cmd       = '0;
      req_ready = 1'b0;
      src       = '0;

      case (state_ff)
         usf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               win_in[cnt_ff[1:0]] = req_in_byte;
               cnt_in   = cnt_ff + 3'd1;
               end_in   = req_in_end;
               state_in = usf_pkg::ST_SCAN;
            end
         end
         usf_pkg::ST_SCAN: begin
            if (cnt_ff == 3'd0 || cls.stall) begin
               state_in = usf_pkg::ST_FINISH;
            end else begin
               cls_in = cls;
               // advance the window past the consumed bytes
               for (int i = 0; i < 4; i++) begin
                  src = 3'(i) + cls.adv;
                  if (src < 3'd4) begin
                     win_in[i] = win_ff[src[1:0]];
                  end
               end
               cnt_in   = cnt_ff - cls.adv;
               idx_in   = '0;
               state_in = usf_pkg::ST_EMIT;
            end
         end
         usf_pkg::ST_EMIT: begin
            if (idx_ff == cls_ff.count) begin
               state_in = usf_pkg::ST_SCAN;
            end else begin
               cmd.push = 1'b1;
               cmd.data = cls_ff.data[idx_ff[1:0]];
               if (sts.push_ok) begin
                  idx_in = idx_ff + 3'd1;
                  if (idx_in == cls_ff.count) begin
                     state_in = usf_pkg::ST_SCAN;
                  end
               end
            end
         end
         usf_pkg::ST_FINISH: begin
            cmd.flush = 1'b1;
            if (sts.flush_ok) begin
               state_in = usf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = usf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= usf_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      win_ff <= win_in;
      end_ff <= end_in;
      idx_ff <= idx_in;
      cls_ff <= cls_in;
   end

   a_idle_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == usf_pkg::ST_IDLE |-> cnt_ff <= 3'd3)
      else $error("more than three bytes pending between requests");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == usf_pkg::ST_IDLE |-> !sts.held)
      else $error("held byte left behind at end of request");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == usf_pkg::ST_SCAN && cnt_ff != 3'd0)
      else $error("accepted request did not start a scan");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == usf_pkg::ST_EMIT |-> idx_ff <= cls_ff.count)
      else $error("emit index ran past the byte count");

   a_end_flush: assert property (@(posedge clock) disable iff (reset)
      state_ff == usf_pkg::ST_FINISH && end_ff |-> cnt_ff == 3'd0)
      else $error("bytes still pending after end of string");

endmodule

>>> sv/usf_classify.sv
// Classification unit: decides the treatment of the oldest byte in the
// window and how many bytes it consumes. Uses usf_pkg.
module usf_classify (
   input  usf_pkg::usf_window_type win,
   input  logic [2:0]              cnt,
   input  logic                    last_in_str,
   output usf_pkg::usf_cls_type    cls
);

   logic [7:0] c;
   logic [2:0] avail;
   logic [2:0] need;
   logic       bad;
   logic       fallback;

   always_comb begin
      c        = win[0];
      avail    = cnt - 3'd1;
      need     = 3'd1;
      bad      = 1'b0;
      fallback = 1'b0;
      cls      = '0;
      cls.adv  = 3'd1;
      cls.data[0] = c;

      if (c < usf_pkg::CHR_SPACE) begin
         if (c inside {usf_pkg::CHR_TAB, usf_pkg::CHR_LF, usf_pkg::CHR_CR}) begin
            cls.count = 3'd1;
         end
      end else if (c < usf_pkg::CHR_DEL) begin
         cls.count = 3'd1;
      end else if (c < usf_pkg::CHR_NBSP) begin
         if (c == usf_pkg::CHR_EURO_IN) begin
            cls.data[0] = usf_pkg::EURO_B0;
            cls.data[1] = usf_pkg::EURO_B1;
            cls.data[2] = usf_pkg::EURO_B2;
            cls.count   = 3'd3;
         end else if (c == usf_pkg::CHR_NEL) begin
            cls.data[0] = usf_pkg::CHR_LF;
            cls.data[1] = usf_pkg::CHR_CR;
            cls.count   = 3'd2;
         end
      end else if (c < usf_pkg::CHR_LEAD_MIN) begin
         cls.data[0] = usf_pkg::PFX_C2;
         cls.data[1] = c;
         cls.count   = 3'd2;
      end else if (c >= usf_pkg::CHR_LEAD2 && c < usf_pkg::CHR_LEAD_END) begin
         if (c < usf_pkg::CHR_LEAD3) begin
            need = 3'd1;
         end else if (c < usf_pkg::CHR_LEAD4) begin
            need = 3'd2;
         end else begin
            need = 3'd3;
         end
         // a bad continuation condemns the lead at once
         for (int k = 1; k < 4; k++) begin
            if (3'(k) <= avail && 3'(k) <= need &&
                !(win[k] inside {[usf_pkg::CHR_CONT_MIN:usf_pkg::CHR_CONT_MAX]})) begin
               bad = 1'b1;
            end
         end
         if (!bad && avail >= need) begin
            cls.adv = need + 3'd1;
            if (!(c == usf_pkg::CHR_LEAD2 && win[1] < usf_pkg::CHR_NBSP)) begin
               cls.data  = win;
               cls.count = need + 3'd1;
            end
         end else if (!bad && !last_in_str) begin
            cls.stall = 1'b1;
         end else begin
            fallback = 1'b1;
         end
      end else begin
         fallback = 1'b1;
      end

      if (fallback) begin
         cls.data[0] = usf_pkg::PFX_C3;
         cls.data[1] = c - usf_pkg::LATIN1_OFFSET;
         cls.count   = 3'd2;
         cls.adv     = 3'd1;
      end
   end

endmodule

>>> sv/usf_emit.sv
// Output stage: one holding register that delays each byte until the next
// is known, so the final byte of a request can be flagged, then the
// response register. Uses usf_pkg.
module usf_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  usf_pkg::usf_emit_cmd_type    cmd,
   output usf_pkg::usf_emit_sts_type    sts,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_out_last
);

   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       out_free;

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      sts.push_ok  = !held_valid_ff || out_free;
      sts.flush_ok = !held_valid_ff || out_free;
      sts.held     = held_valid_ff;

      if (cmd.push && sts.push_ok) begin
         if (held_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = held_byte_ff;
            rsp_last_in  = 1'b0;
         end
         held_valid_in = 1'b1;
         held_byte_in  = cmd.data;
      end else if (cmd.flush && held_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = held_byte_ff;
         rsp_last_in   = 1'b1;
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      held_byte_ff <= held_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

>>> sim/utf8_stream_sanitizer_tb.sv
// Self-checking bench for utf8_stream_sanitizer: directed and random byte streams,
// a cleaned-byte predictor in a small scoreboard class, random idling on both sides.
// Depends on usf_pkg and the utf8_stream_sanitizer RTL only.
module utf8_stream_sanitizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned ITEM_TARGET  = 460;
   localparam int unsigned TAIL_CYCLES  = 64;
   localparam int unsigned HOLD_AFTER   = 150;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_AFTER  = 300;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } clean_byte_type;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_COIN,
      RX_SPARSE,
      RX_TOGGLE
   } rx_mode_type;

   class usf_scoreboard;
      logic [7:0]     held_bytes [3];
      int unsigned    held_count;
      clean_byte_type clean_q [$];
      int unsigned    err_count;

      function new();
         held_count = 0;
         err_count  = 0;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         err_count++;
      endtask

      function int unsigned waiting();
         return clean_q.size();
      endfunction

      // work out the cleaned bytes that one accepted request decides
      function void note_request(logic [7:0] raw, logic at_end);
         logic [7:0]     win [4];
         logic [7:0]     outb [$];
         logic [7:0]     c;
         int unsigned    n, head, need, avail, look;
         logic           broken, decided, stop;
         clean_byte_type entry;
         for (int i = 0; i < held_count; i++) win[i] = held_bytes[i];
         win[held_count] = raw;
         n    = held_count + 1;
         head = 0;
         stop = 1'b0;
         while (head < n && !stop) begin
            c = win[head];
            if (c < usf_pkg::CHR_SPACE) begin
               if (c == usf_pkg::CHR_TAB || c == usf_pkg::CHR_LF ||
                   c == usf_pkg::CHR_CR)
                  outb.push_back(c);
               head++;
            end else if (c < usf_pkg::CHR_DEL) begin
               outb.push_back(c);
               head++;
            end else if (c < usf_pkg::CHR_NBSP) begin
               if (c == usf_pkg::CHR_EURO_IN) begin
                  outb.push_back(usf_pkg::EURO_B0);
                  outb.push_back(usf_pkg::EURO_B1);
                  outb.push_back(usf_pkg::EURO_B2);
               end else if (c == usf_pkg::CHR_NEL) begin
                  outb.push_back(usf_pkg::CHR_LF);
                  outb.push_back(usf_pkg::CHR_CR);
               end
               head++;
            end else if (c < usf_pkg::CHR_LEAD_MIN) begin
               outb.push_back(usf_pkg::PFX_C2);
               outb.push_back(c);
               head++;
            end else begin
               decided = 1'b0;
               if (c >= usf_pkg::CHR_LEAD2 && c < usf_pkg::CHR_LEAD_END) begin
                  need   = (c < usf_pkg::CHR_LEAD3) ? 1 : (c < usf_pkg::CHR_LEAD4) ? 2 : 3;
                  avail  = n - head - 1;
                  look   = (avail < need) ? avail : need;
                  broken = 1'b0;
                  for (int k = 1; k <= look; k++)
                     if (win[head+k] < usf_pkg::CHR_CONT_MIN ||
                         win[head+k] > usf_pkg::CHR_CONT_MAX)
                        broken = 1'b1;
                  if (!broken && avail >= need) begin
                     // C2 with a C1 control behind it is dropped whole
                     if (!(c == usf_pkg::PFX_C2 && win[head+1] < usf_pkg::CHR_NBSP))
                        for (int k = 0; k <= need; k++) outb.push_back(win[head+k]);
                     head    = head + need + 1;
                     decided = 1'b1;
                  end else if (!broken && !at_end) begin
                     stop    = 1'b1;
                     decided = 1'b1;
                  end
               end
               if (!decided) begin
                  outb.push_back(usf_pkg::PFX_C3);
                  outb.push_back(c - usf_pkg::LATIN1_OFFSET);
                  head++;
               end
            end
         end
         held_count = n - head;
         for (int i = 0; i < held_count; i++) held_bytes[i] = win[head+i];
         foreach (outb[i]) begin
            entry.data = outb[i];
            entry.last = (i == outb.size() - 1);
            clean_q.push_back(entry);
         end
      endfunction

      task check_response(logic [7:0] data, logic last);
         clean_byte_type exp_b;
         if (clean_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h last %b", data, last));
            return;
         end
         exp_b = clean_q.pop_front();
         if (data !== exp_b.data)
            report_mismatch($sformatf("out_byte %h, expected %h", data, exp_b.data));
         if (last !== exp_b.last)
            report_mismatch($sformatf("out_last %b, expected %b (byte %h)",
                                      last, exp_b.last, exp_b.data));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_in_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   usf_scoreboard sb = new();

   int unsigned sent_count     = 0;
   int unsigned accepted_count = 0;
   int unsigned burst_left     = 1;
   int unsigned cycle_count    = 0;

   utf8_stream_sanitizer i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_end   (req_in_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf8_stream_sanitizer verification failed");
         $finish;
      end
   end

   // sample at the falling edge, clear of the rising-edge updates
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_out_byte, rsp_out_last);
         if (req_valid && req_ready) begin
            sb.note_request(req_in_byte, req_in_end);
            accepted_count++;
         end
      end
   end

   // receiver: stall pattern changes every so often, with one long hold-off
   rx_mode_type rx_mode   = RX_FREE;
   int unsigned mode_left = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && accepted_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_FREE:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ready <= !rsp_ready;
            endcase
         end
      end
   end

   // offer one request and hold it until taken; idle between bursts
   task automatic put_byte(input logic [7:0] raw, input logic at_end);
      logic        took;
      int unsigned gap;
      req_valid   <= 1'b1;
      req_in_byte <= raw;
      req_in_end  <= at_end;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end
      sent_count++;
      if (burst_left > 1) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   function automatic logic [7:0] pick_lead(int unsigned len);
      case (len)
         2:       return 8'($urandom_range(usf_pkg::CHR_LEAD2, usf_pkg::CHR_LEAD3 - 1));
         3:       return 8'($urandom_range(usf_pkg::CHR_LEAD3, usf_pkg::CHR_LEAD4 - 1));
         default: return 8'($urandom_range(usf_pkg::CHR_LEAD4, usf_pkg::CHR_LEAD_END - 1));
      endcase
   endfunction

   function automatic logic [7:0] pick_cont();
      return 8'($urandom_range(usf_pkg::CHR_CONT_MIN, usf_pkg::CHR_CONT_MAX));
   endfunction

   task automatic directed_part();
      logic [7:0] singles [11] = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h20, 8'h7E, 8'h7F,
                                   8'h80, 8'h85, 8'hA0, 8'hC1};
      foreach (singles[i]) put_byte(singles[i], 1'b0);
      // C2 with a C1 control: dropped
      put_byte(8'hC2, 1'b0);
      put_byte(8'h85, 1'b0);
      put_byte(8'hE2, 1'b0);
      put_byte(8'h82, 1'b0);
      put_byte(8'hAC, 1'b0);
      put_byte(8'hF4, 1'b0);
      put_byte(8'h8F, 1'b0);
      put_byte(8'hBF, 1'b0);
      put_byte(8'hBF, 1'b0);
      // bad continuation decides the lead at once
      put_byte(8'hE0, 1'b0);
      put_byte(8'h41, 1'b0);
      // lead cut off by the end of the string
      put_byte(8'hF0, 1'b0);
      put_byte(8'h90, 1'b1);
      put_byte(8'hFF, 1'b1);
   endtask

   task automatic random_part();
      int unsigned kind, len, good;
      bit          drained;
      drained = 1'b0;
      while (sent_count < ITEM_TARGET) begin
         if (!drained && sent_count >= DRAIN_AFTER) begin
            // pause the sender until every cleaned byte has come out
            drained = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.waiting() != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            len = $urandom_range(2, 4);
            put_byte(pick_lead(len), ($urandom_range(0, 29) == 0));
            for (int k = 1; k < len; k++)
               put_byte(pick_cont(), (k == len - 1) ? ($urandom_range(0, 9) == 0)
                                                    : ($urandom_range(0, 29) == 0));
         end else if (kind < 65) begin
            put_byte(8'($urandom_range(0, 127)), ($urandom_range(0, 9) == 0));
         end else if (kind < 85) begin
            put_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
         end else begin
            // broken sequence: short of continuations, then a stray byte or the end
            len  = $urandom_range(2, 4);
            good = $urandom_range(0, len - 2);
            if (good == 0 && $urandom_range(0, 1) == 1) begin
               put_byte(pick_lead(len), 1'b1);
            end else begin
               put_byte(pick_lead(len), 1'b0);
               for (int k = 0; k < good; k++) put_byte(pick_cont(), 1'b0);
               if ($urandom_range(0, 1) == 1)
                  put_byte(8'($urandom_range(0, 127)), ($urandom_range(0, 7) == 0));
               else
                  put_byte(8'($urandom_range(usf_pkg::CHR_LEAD_MIN, 255)),
                           ($urandom_range(0, 7) == 0));
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_part();
      random_part();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.waiting() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.waiting() != 0)
         sb.report_mismatch($sformatf("%0d cleaned bytes never arrived", sb.waiting()));
      if (sb.err_count == 0)
         $display("utf8_stream_sanitizer verification clean");
      else
         $display("utf8_stream_sanitizer verification failed");
      $finish;
   end

endmodule
